// ===== hdl/tplb_pkg.sv =====
// Shared types and constants for the TCP port load balancer.
package tplb_pkg;

  localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
  localparam logic [15:0] IP_HDR_END     = 16'd34;
  localparam logic [15:0] TCP_HDR_END    = 16'd54;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [1:0] VERDICT_DROP = 2'd0;
  localparam logic [1:0] VERDICT_PASS = 2'd1;
  localparam logic [1:0] VERDICT_TX   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MATCH_PORT     = 2'd0;
  localparam logic [1:0] REG_BACKEND_ADDR   = 2'd1;
  localparam logic [1:0] REG_BACKEND_PORT_A = 2'd2;
  localparam logic [1:0] REG_BACKEND_PORT_B = 2'd3;

  localparam logic [15:0] MATCH_PORT_RST     = 16'd8080;
  localparam logic [31:0] BACKEND_ADDR_RST   = 32'h7f00_0001;
  localparam logic [15:0] BACKEND_PORT_A_RST = 16'd5000;
  localparam logic [15:0] BACKEND_PORT_B_RST = 16'd6000;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
    logic        pick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] new_dest_addr;
    logic [15:0] new_dest_port;
    logic [15:0] new_ip_sum;
    logic [15:0] new_tcp_sum;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] dest_addr;
    logic [15:0] dest_port;
    logic [15:0] ip_sum;
    logic [15:0] tcp_sum;
    logic        pick;
  } entry_t;

  // Rewrite targets used by the back part
  typedef struct packed {
    logic [31:0] backend_addr;
    logic [15:0] backend_port_a;
    logic [15:0] backend_port_b;
  } backend_cfg_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/tplb_front.sv =====
// Front part: accepts requests, classifies them and holds one for the queue.
module tplb_front
  import tplb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  input  logic [15:0] match_port,
  input  q_stat_t     q_stat,
  output logic        push,
  output entry_t      push_entry
);

  logic   valid_r, valid_nxt;
  entry_t entry_r;
  logic   accept;
  logic [1:0] verdict;

  // Classify by header lengths, ether type, protocol and port
  always_comb begin
    if (in_item.frame_length < ETH_HDR_LEN) begin
      verdict = VERDICT_DROP;
    end else if (in_item.ether_type != ETHERTYPE_IPV4) begin
      verdict = VERDICT_PASS;
    end else if (in_item.frame_length < IP_HDR_END) begin
      verdict = VERDICT_DROP;
    end else if (in_item.ip_protocol != PROTO_TCP) begin
      verdict = VERDICT_PASS;
    end else if (in_item.frame_length < TCP_HDR_END) begin
      verdict = VERDICT_DROP;
    end else if (in_item.dest_port != match_port) begin
      verdict = VERDICT_PASS;
    end else begin
      verdict = VERDICT_TX;
    end
  end

  // Stall only while the held request cannot enter the queue
  assign busy   = valid_r && q_stat.full;
  assign accept = start && !busy;
  assign push   = valid_r && !q_stat.full;
  assign push_entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the classified request
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r.verdict   <= verdict;
      entry_r.dest_addr <= in_item.dest_addr;
      entry_r.dest_port <= in_item.dest_port;
      entry_r.ip_sum    <= in_item.ip_sum;
      entry_r.tcp_sum   <= in_item.tcp_sum;
      entry_r.pick      <= in_item.pick;
    end
  end

endmodule

// ===== hdl/tplb_queue.sv =====
// Short FIFO between the front and back parts.
module tplb_queue
  import tplb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  pop_entry,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

  entry_t          slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign q_stat.full  = (count_r == DEPTH_C);
  assign q_stat.empty = (count_r == '0);
  assign do_push   = push && !q_stat.full;
  assign do_pop    = pop && !q_stat.empty;
  assign pop_entry = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the last slot
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/tplb_back.sv =====
// Back part: for transmitted requests, rewrites address and port and updates both checksums.
module tplb_back
  import tplb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  backend_cfg_t cfg,
  input  q_stat_t      q_stat,
  input  entry_t       pop_entry,
  output logic         pop,
  output logic         out_valid,
  output out_item_t    out_item
);

  logic        s1_valid_r;
  logic [1:0]  s1_verdict_r;
  logic [31:0] s1_addr_r;
  logic [15:0] s1_port_r;
  logic [15:0] s1_ip_sum_r, s1_tcp_sum_r;
  logic [18:0] s1_ip_acc_r, s1_tcp_acc_r;

  logic        rewrite;
  logic [15:0] new_port;
  logic [18:0] ip_acc, tcp_acc;
  logic [16:0] ip_f1, tcp_f1;
  logic [15:0] ip_f2, tcp_f2;
  out_item_t   res;
  logic        out_valid_r;
  out_item_t   out_item_r;

  // Drain one request every cycle the queue holds one
  assign pop      = !q_stat.empty;
  assign rewrite  = (pop_entry.verdict == VERDICT_TX);
  assign new_port = pop_entry.pick ? cfg.backend_port_b : cfg.backend_port_a;

  // Sum ~old + new over every changed word, on top of ~checksum
  always_comb begin
    ip_acc = {3'b000, ~pop_entry.ip_sum}
           + {3'b000, ~pop_entry.dest_addr[31:16]} + 19'(cfg.backend_addr[31:16])
           + {3'b000, ~pop_entry.dest_addr[15:0]}  + 19'(cfg.backend_addr[15:0]);
    tcp_acc = {3'b000, ~pop_entry.tcp_sum}
            + {3'b000, ~pop_entry.dest_addr[31:16]} + 19'(cfg.backend_addr[31:16])
            + {3'b000, ~pop_entry.dest_addr[15:0]}  + 19'(cfg.backend_addr[15:0])
            + {3'b000, ~pop_entry.dest_port} + 19'(new_port);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_verdict_r <= pop_entry.verdict;
      s1_addr_r    <= rewrite ? cfg.backend_addr : pop_entry.dest_addr;
      s1_port_r    <= rewrite ? new_port : pop_entry.dest_port;
      s1_ip_sum_r  <= pop_entry.ip_sum;
      s1_tcp_sum_r <= pop_entry.tcp_sum;
      s1_ip_acc_r  <= ip_acc;
      s1_tcp_acc_r <= tcp_acc;
    end
  end

  // Fold carries back in twice, then complement; other verdicts keep their sums
  always_comb begin
    ip_f1  = 17'(s1_ip_acc_r[15:0]) + 17'(s1_ip_acc_r[18:16]);
    tcp_f1 = 17'(s1_tcp_acc_r[15:0]) + 17'(s1_tcp_acc_r[18:16]);
    ip_f2  = ip_f1[15:0] + 16'(ip_f1[16]);
    tcp_f2 = tcp_f1[15:0] + 16'(tcp_f1[16]);
    res.verdict       = s1_verdict_r;
    res.new_dest_addr = s1_addr_r;
    res.new_dest_port = s1_port_r;
    if (s1_verdict_r == VERDICT_TX) begin
      res.new_ip_sum  = ~ip_f2;
      res.new_tcp_sum = ~tcp_f2;
    end else begin
      res.new_ip_sum  = s1_ip_sum_r;
      res.new_tcp_sum = s1_tcp_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/tcp_port_load_balance_rewrite.sv =====
// Top level of the TCP port load balancer with configuration registers.
//
// One request is accepted per clock cycle while busy is low; its result shows
// on out_item with out_valid high for exactly one cycle, after it has passed
// the front register, queue slot, checksum sum stage, checksum fold and output
// register. The result side cannot stall, so the back part drains the queue
// every cycle and busy stays low in steady operation; it rises only if the
// queue between front and back is full. Results leave in request order.
// Configuration is to be written through the APB port only while no request
// is in flight; the block itself does not enforce this. match_port is used
// when a request is classified, the backend address and ports when it is
// rewritten.
module tcp_port_load_balance_rewrite
  import tplb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]  match_port_r;
  backend_cfg_t backend_r;
  logic         cfg_wr;
  logic [1:0]   reg_idx;
  logic         push, pop;
  entry_t       push_entry, pop_entry;
  q_stat_t      q_stat;

  // Register file on the APB port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r             <= MATCH_PORT_RST;
      backend_r.backend_addr   <= BACKEND_ADDR_RST;
      backend_r.backend_port_a <= BACKEND_PORT_A_RST;
      backend_r.backend_port_b <= BACKEND_PORT_B_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MATCH_PORT:     match_port_r             <= pwdata[15:0];
        REG_BACKEND_ADDR:   backend_r.backend_addr   <= pwdata;
        REG_BACKEND_PORT_A: backend_r.backend_port_a <= pwdata[15:0];
        REG_BACKEND_PORT_B: backend_r.backend_port_b <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_MATCH_PORT:     prdata = {16'd0, match_port_r};
      REG_BACKEND_ADDR:   prdata = backend_r.backend_addr;
      REG_BACKEND_PORT_A: prdata = {16'd0, backend_r.backend_port_a};
      REG_BACKEND_PORT_B: prdata = {16'd0, backend_r.backend_port_b};
      default:            prdata = '0;
    endcase
  end

  tplb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .match_port (match_port_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  tplb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  tplb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (backend_r),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/tplb_checker.sv =====
// Port-level checks for the TCP port load balancer, bound to the top level.
module tplb_checker
  import tplb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  logic accept;
  assign accept = start && !busy;

  // Every accepted request yields a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted request produced no result");

  // No result without a request behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result without a matching request");

  // Verdict code stays within drop, pass, transmit
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.verdict == VERDICT_DROP ||
                   out_item.verdict == VERDICT_PASS ||
                   out_item.verdict == VERDICT_TX))
    else $error("illegal verdict code");

  // Drop and pass leave the header fields untouched
  a_untouched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.verdict != VERDICT_TX) |->
      (out_item.new_dest_addr == $past(in_item.dest_addr, 4) &&
       out_item.new_dest_port == $past(in_item.dest_port, 4) &&
       out_item.new_ip_sum    == $past(in_item.ip_sum, 4) &&
       out_item.new_tcp_sum   == $past(in_item.tcp_sum, 4)))
    else $error("pass or drop altered header fields");

endmodule

bind tcp_port_load_balance_rewrite tplb_checker u_tplb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
